>>> hdl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// shared constants and types for the lru page replacement block
// ----------------------------------------------------------------------------
package lru_pkg;

	localparam int FRAMES_DEF    = 5;
	localparam int PAGE_BITS_DEF = 16;
	localparam int CNT_W         = 32;
	localparam int OUTCOME_W     = 2;

	localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

	// control broadcast from the top level to every cell
	typedef struct packed {
		logic go;
		logic hit_any;
		logic full;
	} lru_ctl_t;

	// status reported by one cell
	typedef struct packed {
		logic valid;
		logic hit;
		logic victim;
		logic sel;
	} lru_stat_t;

endpackage

>>> hdl/lru_cell.sv
// ----------------------------------------------------------------------------
// lru_cell
// one frame: resident page, valid bit and recency rank, with local compare
// ----------------------------------------------------------------------------
module lru_cell
	import lru_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int AGE_W     = $clog2(FRAMES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lru_ctl_t             ctl,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [AGE_W-1:0]     hit_age,
	input  logic                 prev_valid,
	output lru_stat_t            stat,
	output logic [PAGE_BITS-1:0] page_q,
	output logic [AGE_W-1:0]     age_q
);

	localparam logic [AGE_W-1:0] OLDEST = AGE_W'(FRAMES - 1);

	logic valid_q;
	logic hit;
	logic victim;
	logic free_slot;
	logic sel;

	assign hit       = valid_q && (page_q == page);
	assign victim    = valid_q && (age_q == OLDEST);
	assign free_slot = !valid_q && prev_valid;

	always_comb begin
		priority if (ctl.hit_any) begin
			sel = hit;
		end else if (ctl.full) begin
			sel = victim;
		end else begin
			sel = free_slot;
		end
	end

	assign stat = '{valid: valid_q, hit: hit, victim: victim, sel: sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (ctl.go) begin
			if (sel) begin
				valid_q <= 1'b1;
				age_q   <= '0;
			end else if (valid_q) begin
				if (!ctl.hit_any || (age_q < hit_age)) begin
					age_q <= age_q + AGE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go && sel && !ctl.hit_any) begin
			page_q <= page;
		end
	end

endmodule

>>> hdl/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// fully associative lru frame set built as a row of frame cells
//
// channel   direction  handshake       payload
// request   in         start / busy    page_number
// result    out        done (strobe)   outcome, frame_index, evicted_page,
//                                      fault_count, access_count
//
// one transaction per cycle: every cell compares the page and updates its
// rank at the accepting edge, the result appears in the next cycle
// busy stays low, the cell row sets the clock period
// reset clears valid bits, ranks and both counters; pages are never cleared
// the receiver cannot stall: done is a one-cycle strobe
// ----------------------------------------------------------------------------
module lru_page_replacement_top
	import lru_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [PAGE_BITS-1:0]        page_number,
	output logic                        done,
	output logic [OUTCOME_W-1:0]        outcome,
	output logic [$clog2(FRAMES)-1:0]   frame_index,
	output logic [PAGE_BITS-1:0]        evicted_page,
	output logic [CNT_W-1:0]            fault_count,
	output logic [CNT_W-1:0]            access_count
);

	localparam int IDX_W = $clog2(FRAMES);

	lru_ctl_t                 ctl;
	lru_stat_t                stat  [FRAMES];
	logic [PAGE_BITS-1:0]     pages [FRAMES];
	logic [IDX_W-1:0]         ages  [FRAMES];
	logic [FRAMES-1:0]        hit_vec;
	logic [FRAMES-1:0]        sel_vec;
	logic [FRAMES-1:0]        victim_vec;
	logic [IDX_W-1:0]         hit_age;
	logic [IDX_W-1:0]         sel_idx;
	logic [PAGE_BITS-1:0]     victim_page;
	logic                     go;
	logic [CNT_W-1:0]         fault_q;
	logic [CNT_W-1:0]         access_q;
	logic [CNT_W-1:0]         fault_nxt;
	logic [CNT_W-1:0]         access_nxt;
	logic [OUTCOME_W-1:0]     outcome_nxt;

	assign busy = 1'b0;
	assign go   = start && !busy;

	assign ctl.go      = go;
	assign ctl.hit_any = |hit_vec;
	assign ctl.full    = stat[FRAMES-1].valid;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		logic prev_valid;
		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = stat[i-1].valid;
		end

		lru_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.AGE_W     (IDX_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.page       (page_number),
			.hit_age    (hit_age),
			.prev_valid (prev_valid),
			.stat       (stat[i]),
			.page_q     (pages[i]),
			.age_q      (ages[i])
		);

		assign hit_vec[i]    = stat[i].hit;
		assign sel_vec[i]    = stat[i].sel;
		assign victim_vec[i] = stat[i].victim;
	end

	always_comb begin
		hit_age     = '0;
		sel_idx     = '0;
		victim_page = '0;
		for (int i = 0; i < FRAMES; i++) begin
			hit_age     = hit_age | (hit_vec[i] ? ages[i] : '0);
			sel_idx     = sel_idx | (sel_vec[i] ? IDX_W'(i) : '0);
			victim_page = victim_page | (victim_vec[i] ? pages[i] : '0);
		end
	end

	always_comb begin
		priority if (ctl.hit_any) begin
			outcome_nxt = OUTCOME_HIT;
		end else if (ctl.full) begin
			outcome_nxt = OUTCOME_EVICT;
		end else begin
			outcome_nxt = OUTCOME_FILL;
		end
	end

	assign access_nxt = (access_q != '1) ? access_q + CNT_W'(1) : access_q;
	assign fault_nxt  = ((outcome_nxt == OUTCOME_EVICT) && (fault_q != '1))
	                    ? fault_q + CNT_W'(1) : fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done     <= 1'b0;
			fault_q  <= '0;
			access_q <= '0;
		end else begin
			done <= go;
			if (go) begin
				fault_q  <= fault_nxt;
				access_q <= access_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			outcome      <= outcome_nxt;
			frame_index  <= sel_idx;
			evicted_page <= (outcome_nxt == OUTCOME_EVICT) ? victim_page : '0;
		end
	end

	assign fault_count  = fault_q;
	assign access_count = access_q;

	// valid pages are distinct, so at most one cell can hit
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one frame hit");

	// every transaction lands in exactly one frame
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> $onehot(sel_vec))
		else $error("transaction selected no frame or several");

	// with all frames valid, ranks form a permutation: one oldest frame
	a_victim_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.full |-> $onehot(victim_vec))
		else $error("full set without a unique oldest frame");

	// fault count only moves on an eviction
	a_fault_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fault_q != $past(fault_q)) |-> (done && (outcome == OUTCOME_EVICT)))
		else $error("fault count changed without an eviction");

endmodule

>>> dv/tb_lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_top
// self-checking bench for the lru page replacement block
//
// a short table of page references fills the frames, hits, evicts and
// re-references, with outcome, frame and evicted page typed in where they
// follow directly from the fill order. random references then draw mostly
// from a small working set so hits and evictions mix, plus full-range pages.
// every transaction is predicted by an in-bench lru frame set, and each done
// strobe is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_top;
	import lru_pkg::*;

	localparam int NFRAMES   = FRAMES_DEF;
	localparam int PW        = PAGE_BITS_DEF;
	localparam int FW        = $clog2(NFRAMES);
	localparam int POOL_N    = 7;
	localparam int RAND_ITEMS = 950;
	localparam int STALL_LIMIT = 2000;
	localparam int EXP_DEPTH = 16;
	localparam int EXP_AW    = $clog2(EXP_DEPTH);

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [FW-1:0]        frame;
		logic [PW-1:0]        evicted;
		logic [CNT_W-1:0]     faults;
		logic [CNT_W-1:0]     accesses;
	} access_result_t;

	typedef struct packed {
		logic [PW-1:0]        page;
		logic                 fixed;
		logic [OUTCOME_W-1:0] outcome;
		logic [FW-1:0]        frame;
		logic [PW-1:0]        evicted;
	} ref_row_t;

	localparam int NROWS = 18;
	localparam ref_row_t REF_TABLE [NROWS] = '{
		'{16'h0000, 1'b1, OUTCOME_FILL,  3'd0, 16'h0000},
		'{16'hFFFF, 1'b1, OUTCOME_FILL,  3'd1, 16'h0000},
		'{16'h0001, 1'b1, OUTCOME_FILL,  3'd2, 16'h0000},
		'{16'h8000, 1'b1, OUTCOME_FILL,  3'd3, 16'h0000},
		'{16'h1234, 1'b1, OUTCOME_FILL,  3'd4, 16'h0000},
		'{16'h0000, 1'b1, OUTCOME_HIT,   3'd0, 16'h0000},
		'{16'h5555, 1'b1, OUTCOME_EVICT, 3'd1, 16'hFFFF},
		'{16'hAAAA, 1'b1, OUTCOME_EVICT, 3'd2, 16'h0001},
		'{16'hAAAA, 1'b1, OUTCOME_HIT,   3'd2, 16'h0000},
		'{16'hFFFF, 1'b1, OUTCOME_EVICT, 3'd3, 16'h8000},
		'{16'h1234, 1'b1, OUTCOME_HIT,   3'd4, 16'h0000},
		'{16'h0000, 1'b1, OUTCOME_HIT,   3'd0, 16'h0000},
		'{16'h7FFF, 1'b0, OUTCOME_HIT,   3'd0, 16'h0000},
		'{16'h5555, 1'b0, OUTCOME_HIT,   3'd0, 16'h0000},
		'{16'hFFFE, 1'b0, OUTCOME_HIT,   3'd0, 16'h0000},
		'{16'h0002, 1'b0, OUTCOME_HIT,   3'd0, 16'h0000},
		'{16'h1234, 1'b0, OUTCOME_HIT,   3'd0, 16'h0000},
		'{16'h7FFF, 1'b0, OUTCOME_HIT,   3'd0, 16'h0000}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [PW-1:0]        page_number;
	logic                 done;
	logic [OUTCOME_W-1:0] outcome;
	logic [FW-1:0]        frame_index;
	logic [PW-1:0]        evicted_page;
	logic [CNT_W-1:0]     fault_count;
	logic [CNT_W-1:0]     access_count;

	// in-bench copy of the frame set
	logic [PW-1:0]        resident_page [NFRAMES];
	bit                   resident_vld  [NFRAMES];
	logic [2:0]           recency       [NFRAMES];
	logic [CNT_W-1:0]     evict_total;
	logic [CNT_W-1:0]     ref_total;

	// pending predictions, oldest at exp_rd
	access_result_t       exp_buf [EXP_DEPTH];
	logic [EXP_AW-1:0]    exp_wr;
	logic [EXP_AW-1:0]    exp_rd;
	int                   exp_cnt;
	access_result_t       want;
	access_result_t       got;
	logic [PW-1:0]        page_pool [POOL_N];
	ref_row_t             cur_row;
	int                   mismatches;
	int                   stall_cycles;

	lru_page_replacement_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.page_number  (page_number),
		.done         (done),
		.outcome      (outcome),
		.frame_index  (frame_index),
		.evicted_page (evicted_page),
		.fault_count  (fault_count),
		.access_count (access_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic lru_predict_access(input logic [PW-1:0] pg, output access_result_t r);
		int hit_f;
		int free_f;
		int victim_f;
		int f;
		int limit;
		hit_f    = -1;
		free_f   = -1;
		victim_f = -1;
		if (ref_total != '1)
			ref_total++;
		for (int i = 0; i < NFRAMES; i++) begin
			if (resident_vld[i]) begin
				if (hit_f < 0 && resident_page[i] == pg)
					hit_f = i;
				if (victim_f < 0 || recency[i] > recency[victim_f])
					victim_f = i;
			end else if (free_f < 0) begin
				free_f = i;
			end
		end
		r.evicted = '0;
		if (hit_f >= 0) begin
			f = hit_f;
			r.outcome = OUTCOME_HIT;
			limit = recency[f];
		end else if (free_f >= 0) begin
			f = free_f;
			r.outcome = OUTCOME_FILL;
			resident_page[f] = pg;
			limit = 255;
		end else begin
			f = victim_f;
			r.outcome = OUTCOME_EVICT;
			r.evicted = resident_page[f];
			resident_page[f] = pg;
			if (evict_total != '1)
				evict_total++;
			limit = 255;
		end
		// frames more recent than the touched one age by one
		for (int i = 0; i < NFRAMES; i++) begin
			if (i != f && resident_vld[i] && recency[i] < limit)
				recency[i] = recency[i] + 3'd1;
		end
		recency[f]      = '0;
		resident_vld[f] = 1'b1;
		r.frame    = FW'(f);
		r.faults   = evict_total;
		r.accesses = ref_total;
	endtask

	// monitor: predict on accept, check on done
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				lru_predict_access(page_number, want);
				if (cur_row.fixed) begin
					want.outcome = cur_row.outcome;
					want.frame   = cur_row.frame;
					want.evicted = cur_row.evicted;
				end
				exp_buf[exp_wr] = want;
				exp_wr          = exp_wr + EXP_AW'(1);
				exp_cnt++;
			end
			if (done) begin
				got = '{outcome, frame_index, evicted_page, fault_count, access_count};
				if (exp_cnt == 0) begin
					mismatches++;
					$display("%0t unexpected transaction: expected none actual %h", $time, got);
				end else begin
					want   = exp_buf[exp_rd];
					exp_rd = exp_rd + EXP_AW'(1);
					exp_cnt--;
					if (got.outcome !== want.outcome) begin
						mismatches++;
						$display("%0t outcome: expected %0d actual %0d",
							$time, want.outcome, got.outcome);
					end
					if (got.frame !== want.frame) begin
						mismatches++;
						$display("%0t frame_index: expected %0d actual %0d",
							$time, want.frame, got.frame);
					end
					if (got.evicted !== want.evicted) begin
						mismatches++;
						$display("%0t evicted_page: expected %h actual %h",
							$time, want.evicted, got.evicted);
					end
					if (got.faults !== want.faults) begin
						mismatches++;
						$display("%0t fault_count: expected %0d actual %0d",
							$time, want.faults, got.faults);
					end
					if (got.accesses !== want.accesses) begin
						mismatches++;
						$display("%0t access_count: expected %0d actual %0d",
							$time, want.accesses, got.accesses);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_lru_page_replacement_top NOT OK");
			$finish;
		end
	end

	task automatic send_page(input ref_row_t row, input int idle_pct);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		cur_row = row;
		start       <= 1'b1;
		page_number <= row.page;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (exp_cnt != 0)
			@(posedge clk);
	endtask

	function automatic logic [PW-1:0] pick_page();
		int sel;
		sel = $urandom_range(99);
		if (sel < 65)
			return page_pool[$urandom_range(POOL_N - 1)];
		else if (sel < 80)
			return PW'($urandom_range(9));
		else
			return PW'($urandom);
	endfunction

	initial begin
		ref_row_t row;
		int idle_pct;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		page_number  = '0;
		cur_row      = '0;
		mismatches   = 0;
		stall_cycles = 0;
		exp_wr       = '0;
		exp_rd       = '0;
		exp_cnt      = 0;
		evict_total  = '0;
		ref_total    = '0;
		for (int i = 0; i < NFRAMES; i++) begin
			resident_page[i] = '0;
			resident_vld[i]  = 1'b0;
			recency[i]       = '0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (REF_TABLE[i])
			send_page(REF_TABLE[i], 15);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 15 : (phase == 1) ? 78 : 0;
			for (int n = 0; n < RAND_ITEMS / 3; n++) begin
				// move the working set now and then
				if (n % 40 == 0)
					foreach (page_pool[k])
						page_pool[k] = PW'($urandom);
				row = '0;
				row.page = pick_page();
				send_page(row, idle_pct);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (exp_cnt != 0) begin
			mismatches++;
			$display("%0t leftover transactions: expected 0 actual %0d",
				$time, exp_cnt);
		end
		if (mismatches == 0)
			$display("tb_lru_page_replacement_top OK");
		else
			$display("tb_lru_page_replacement_top NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
hdl/lru_pkg.sv
hdl/lru_cell.sv
hdl/lru_page_replacement_top.sv
dv/tb_lru_page_replacement_top.sv
